[sv/cws_pkg.sv]
`timescale 1ns / 1ps

package cws_pkg;

    localparam int MAX_RADIUS    = 8;
    localparam int SAMPLE_BITS   = 16;
    localparam int HIST_DEPTH    = 2 * MAX_RADIUS + 1;
    localparam int SUM_BITS      = SAMPLE_BITS + $clog2(HIST_DEPTH);
    localparam int CFG_BITS      = 4;
    localparam int RADIUS_BITS   = $clog2(MAX_RADIUS + 1);
    localparam int SEEN_BITS     = $clog2(MAX_RADIUS + 2);
    localparam int HIST_IDX_BITS = $clog2(HIST_DEPTH);
    localparam int CMDQ_DEPTH    = 4;
    localparam int CMDQ_PTR_BITS = 2;
    localparam int CMDQ_CNT_BITS = 3;
    localparam int RESQ_DEPTH    = 2;
    localparam int RESQ_CNT_BITS = 2;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [SUM_BITS-1:0]    sum_t;
    typedef logic [CFG_BITS-1:0]           cfg_t;
    typedef logic [RADIUS_BITS-1:0]        radius_t;
    typedef logic [SEEN_BITS-1:0]          seen_t;
    typedef logic [HIST_IDX_BITS-1:0]      hidx_t;

    typedef struct packed {
        sample_t sample;
        logic    end_of_vector;
    } in_t;

    typedef struct packed {
        sum_t window_sum;
        logic last_sum;
    } out_t;

    // Work item handed from the classifier to the summing datapath
    typedef struct packed {
        sample_t sample;
        logic    emit;
        logic    last;
        radius_t flush_cnt;
    } cmd_t;

    function automatic radius_t eff_radius(cfg_t value);
        if (int'(value) > MAX_RADIUS)
            return radius_t'(MAX_RADIUS);
        else
            return radius_t'(value);
    endfunction

endpackage

[sv/cws_front.sv]
`timescale 1ns / 1ps

module cws_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  cws_pkg::in_t   sample_item,
    input  cws_pkg::radius_t radius,
    output logic           cmd_push,
    output cws_pkg::cmd_t  cmd,
    input  logic           cmd_full
);
    import cws_pkg::*;

    seen_t   seen_reg;
    seen_t   seen_next;
    seen_t   seen_plus;
    seen_t   seen_less;
    radius_t dmax;

    assign full     = cmd_full;
    assign cmd_push = push && !cmd_full;

    // Saturate the count once the window is full on the left
    assign seen_plus = (seen_reg == seen_t'(MAX_RADIUS + 1)) ? seen_reg : seen_reg + 1'b1;
    assign seen_less = seen_plus - 1'b1;
    assign dmax      = (seen_less < seen_t'(radius)) ? radius_t'(seen_less) : radius;

    always_comb
    begin
        cmd.sample    = sample_item.sample;
        cmd.last      = sample_item.end_of_vector;
        cmd.emit      = seen_plus > seen_t'(radius);
        cmd.flush_cnt = dmax;
    end

    always_comb
    begin
        seen_next = seen_reg;
        if (cmd_push)
        begin
            if (sample_item.end_of_vector)
                seen_next = '0;
            else
                seen_next = seen_plus;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_reg <= '0;
        else
            seen_reg <= seen_next;
    end

endmodule

[sv/cws_cmd_queue.sv]
`timescale 1ns / 1ps

module cws_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cws_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output cws_pkg::cmd_t head,
    output logic          empty
);
    import cws_pkg::*;

    cmd_t                     mem_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_BITS-1:0] wr_ptr_reg;
    logic [CMDQ_PTR_BITS-1:0] rd_ptr_reg;
    logic [CMDQ_CNT_BITS-1:0] cnt_reg;
    logic                     do_push;
    logic                     do_pop;

    assign full    = cnt_reg == CMDQ_CNT_BITS'(CMDQ_DEPTH);
    assign empty   = cnt_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

[sv/cws_back.sv]
`timescale 1ns / 1ps

module cws_back (
    input  logic             clk,
    input  logic             rst_n,
    input  cws_pkg::cmd_t    cmd,
    input  logic             cmd_empty,
    output logic             cmd_pop,
    input  cws_pkg::radius_t radius,
    input  logic             radius_we,
    input  logic             pop,
    output logic             empty,
    output cws_pkg::out_t    sum_item
);
    import cws_pkg::*;

    typedef enum logic [2:0] {
        ST_RUN   = 3'b001,
        ST_FLUSH = 3'b010,
        ST_SYNC  = 3'b100
    } state_t;

    state_t  state_reg, state_next;
    sample_t hist_reg  [HIST_DEPTH];
    sample_t hist_next [HIST_DEPTH];
    sum_t    total_reg, total_next;
    radius_t d_reg, d_next;
    hidx_t   sync_idx_reg, sync_idx_next;

    out_t                     res_mem_reg [RESQ_DEPTH];
    logic                     res_wr_ptr_reg;
    logic                     res_rd_ptr_reg;
    logic [RESQ_CNT_BITS-1:0] res_cnt_reg;
    logic                     res_push;
    out_t                     res_data;
    logic                     res_room;
    logic                     res_pop;

    hidx_t two_r;
    sum_t  stepped;
    sum_t  flushed;

    assign res_room = res_cnt_reg != RESQ_CNT_BITS'(RESQ_DEPTH);
    assign two_r    = hidx_t'(radius) << 1;
    // Add the newest sample, drop the one leaving the window
    assign stepped  = total_reg + sum_t'(cmd.sample) - sum_t'(hist_reg[two_r]);
    assign flushed  = total_reg - sum_t'(hist_reg[hidx_t'(d_reg) + hidx_t'(radius)]);

    always_comb
    begin
        state_next    = state_reg;
        hist_next     = hist_reg;
        total_next    = total_reg;
        d_next        = d_reg;
        sync_idx_next = sync_idx_reg;
        cmd_pop       = 1'b0;
        res_push      = 1'b0;
        res_data      = '0;

        if (radius_we)
        begin
            // Rebuild the running total for the new window width
            state_next    = ST_SYNC;
            total_next    = '0;
            sync_idx_next = '0;
        end
        else
        begin
            unique case (state_reg)
                ST_RUN:
                begin
                    if (!cmd_empty && res_room)
                    begin
                        cmd_pop      = 1'b1;
                        hist_next[0] = cmd.sample;
                        for (int k = 1; k < HIST_DEPTH; k++)
                            hist_next[k] = hist_reg[k-1];
                        total_next = stepped;
                        if (cmd.last)
                        begin
                            res_push            = 1'b1;
                            res_data.window_sum = stepped;
                            res_data.last_sum   = cmd.flush_cnt == '0;
                            if (cmd.flush_cnt == '0)
                            begin
                                for (int k = 0; k < HIST_DEPTH; k++)
                                    hist_next[k] = '0;
                                total_next = '0;
                            end
                            else
                            begin
                                state_next = ST_FLUSH;
                                d_next     = cmd.flush_cnt;
                            end
                        end
                        else if (cmd.emit)
                        begin
                            res_push            = 1'b1;
                            res_data.window_sum = stepped;
                            res_data.last_sum   = 1'b0;
                        end
                    end
                end
                ST_FLUSH:
                begin
                    if (res_room)
                    begin
                        // Shrink from the old end, one position per cycle with room
                        res_push            = 1'b1;
                        res_data.window_sum = flushed;
                        res_data.last_sum   = d_reg == radius_t'(1);
                        if (d_reg == radius_t'(1))
                        begin
                            for (int k = 0; k < HIST_DEPTH; k++)
                                hist_next[k] = '0;
                            total_next = '0;
                            state_next = ST_RUN;
                        end
                        else
                        begin
                            total_next = flushed;
                        end
                        d_next = d_reg - 1'b1;
                    end
                end
                ST_SYNC:
                begin
                    total_next = total_reg + sum_t'(hist_reg[sync_idx_reg]);
                    if (sync_idx_reg == two_r)
                        state_next = ST_RUN;
                    else
                        sync_idx_next = sync_idx_reg + 1'b1;
                end
                default:
                begin
                    state_next = ST_RUN;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_RUN;
            total_reg    <= '0;
            d_reg        <= '0;
            sync_idx_reg <= '0;
            for (int k = 0; k < HIST_DEPTH; k++)
                hist_reg[k] <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            d_reg        <= d_next;
            sync_idx_reg <= sync_idx_next;
            hist_reg     <= hist_next;
        end
    end

    // Result queue toward the consumer
    assign empty    = res_cnt_reg == '0;
    assign res_pop  = pop && !empty;
    assign sum_item = res_mem_reg[res_rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (res_push)
            res_mem_reg[res_wr_ptr_reg] <= res_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_ptr_reg <= 1'b0;
            res_rd_ptr_reg <= 1'b0;
            res_cnt_reg    <= '0;
        end
        else
        begin
            if (res_push)
                res_wr_ptr_reg <= ~res_wr_ptr_reg;
            if (res_pop)
                res_rd_ptr_reg <= ~res_rd_ptr_reg;
            if (res_push && !res_pop)
                res_cnt_reg <= res_cnt_reg + 1'b1;
            else if (res_pop && !res_push)
                res_cnt_reg <= res_cnt_reg - 1'b1;
        end
    end

endmodule

[sv/centered_window_sum_stencil.sv]
`timescale 1ns / 1ps
// Streaming box sum over a window of radius samples on each side of every
// position of a vector, with zero padding past both ends.
// Input side is a queue: a sample request goes in when push is high and
// full is low; end_of_vector marks the vector's final sample.
// Result side is a queue: while empty is low the oldest sum is on sum_item,
// and pop takes it. last_sum marks the sum of the vector's final position.
// radius_we writes radius_data; values above the maximum radius saturate.
// Write it only while no request is in flight; the running total is then
// rebuilt over the stored history before the next sample is summed.
// Throughput: one sample per cycle while the result queue has room and
// no flush or rebuild runs, set by the single add-and-subtract update of
// the running total. The final sample of a vector is followed by up to
// radius flushed sums (fewer for short vectors), during which no new
// sample is summed. An accepted sample waits in the command queue; the
// summing datapath reads it and registers the sum it completes into the
// result queue, whose oldest entry is on sum_item.
// When the consumer stalls, the result queue fills, then the command
// queue fills, then full rises. Reset clears history, counts and queues
// and sets the radius to 3.

module centered_window_sum_stencil (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  cws_pkg::in_t        sample_item,
    output logic                empty,
    input  logic                pop,
    output cws_pkg::out_t       sum_item,
    input  logic                radius_we,
    input  logic [3:0]          radius_data
);
    import cws_pkg::*;

    cfg_t    radius_reg;
    radius_t radius;
    logic    cmd_push;
    cmd_t    cmd_in;
    logic    cmd_full;
    logic    cmd_pop;
    cmd_t    cmd_head;
    logic    cmd_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= cfg_t'(3);
        else if (radius_we)
            radius_reg <= radius_data;
    end

    assign radius = eff_radius(radius_reg);

    cws_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .sample_item (sample_item),
        .radius      (radius),
        .cmd_push    (cmd_push),
        .cmd         (cmd_in),
        .cmd_full    (cmd_full)
    );

    cws_cmd_queue u_cmd_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .head      (cmd_head),
        .empty     (cmd_empty)
    );

    cws_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_head),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .radius    (radius),
        .radius_we (radius_we),
        .pop       (pop),
        .empty     (empty),
        .sum_item  (sum_item)
    );

endmodule
